/* design/ias_pkg.sv */
package ias_pkg;

  localparam int unsigned FuncW        = 3;
  localparam int unsigned IndexW       = 9;
  localparam int unsigned DataW        = 32;
  localparam int unsigned OccW         = 9;
  localparam int unsigned DefaultDepth = 256;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH   = FuncW'(0),
    FUNC_POP    = FuncW'(1),
    FUNC_GET    = FuncW'(2),
    FUNC_INSERT = FuncW'(3),
    FUNC_REMOVE = FuncW'(4)
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] data;
    logic [OccW-1:0]         occ;
  } result_t;

endpackage

/* design/ias_ram.sv */
module ias_ram #(
  parameter int unsigned Depth = ias_pkg::DefaultDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AddrW-1:0]               waddr_i,
  input  logic signed [ias_pkg::DataW-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [AddrW-1:0]               raddr_i,
  output logic signed [ias_pkg::DataW-1:0] rdata_o
);

  logic signed [ias_pkg::DataW-1:0] mem [Depth];
  logic signed [ias_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ias_seq.sv */
module ias_seq #(
  parameter int unsigned Depth = ias_pkg::DefaultDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ias_pkg::FuncW-1:0]        func_i,
  input  logic [ias_pkg::IndexW-1:0]       index_i,
  input  logic signed [ias_pkg::DataW-1:0] value_i,
  output logic                             mem_we_o,
  output logic [AddrW-1:0]                 mem_waddr_o,
  output logic signed [ias_pkg::DataW-1:0] mem_wdata_o,
  output logic                             mem_re_o,
  output logic [AddrW-1:0]                 mem_raddr_o,
  input  logic signed [ias_pkg::DataW-1:0] mem_rdata_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output ias_pkg::result_t                 res_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > ias_pkg::IndexW) ? CntW : ias_pkg::IndexW;

  ias_pkg::state_e state_q, state_d;

  logic [CntW-1:0]                  count_q, count_d;
  logic [AddrW-1:0]                 ptr_q, ptr_d;
  logic [AddrW-1:0]                 last_q, last_d;
  logic [AddrW-1:0]                 rd_addr_q, rd_addr_d;
  logic [AddrW-1:0]                 wr_addr_q, wr_addr_d;
  logic                             up_q, up_d;
  logic                             rd_more_q, rd_more_d;
  logic                             pend_q, pend_d;
  logic                             capture_q, capture_d;
  logic                             do_write_q, do_write_d;
  logic signed [ias_pkg::DataW-1:0] val_q, val_d;
  ias_pkg::result_t                 res_q, res_d;

  logic [CmpW-1:0]  idx_ext, cnt_ext;
  logic [CntW-1:0]  cnt_m1;
  logic [AddrW-1:0] idx_addr;
  logic             full, empty;
  logic             op_ok, op_scan, op_write;

  assign idx_ext  = CmpW'(index_i);
  assign cnt_ext  = CmpW'(count_q);
  assign cnt_m1   = count_q - CntW'(1);
  assign idx_addr = idx_ext[AddrW-1:0];
  assign full     = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);

  always_comb begin
    op_ok    = 1'b0;
    op_scan  = 1'b0;
    op_write = 1'b0;
    unique case (ias_pkg::func_e'(func_i))
      ias_pkg::FUNC_PUSH: begin
        op_ok    = !full;
        op_write = 1'b1;
      end
      ias_pkg::FUNC_POP: begin
        op_ok   = !empty;
        op_scan = 1'b1;
      end
      ias_pkg::FUNC_GET: begin
        op_ok   = (idx_ext < cnt_ext);
        op_scan = 1'b1;
      end
      ias_pkg::FUNC_INSERT: begin
        op_ok    = (idx_ext <= cnt_ext) && !full;
        op_write = 1'b1;
        op_scan  = (idx_ext != cnt_ext);
      end
      ias_pkg::FUNC_REMOVE: begin
        op_ok   = (idx_ext < cnt_ext);
        op_scan = 1'b1;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ias_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority if (!op_ok) begin
            state_d = ias_pkg::ST_FINISH;
          end else if (op_scan) begin
            state_d = ias_pkg::ST_SCAN;
          end else if (op_write) begin
            state_d = ias_pkg::ST_WRITE;
          end else begin
            state_d = ias_pkg::ST_FINISH;
          end
        end
      end
      ias_pkg::ST_SCAN: begin
        if (!rd_more_q && !pend_q) begin
          state_d = do_write_q ? ias_pkg::ST_WRITE : ias_pkg::ST_FINISH;
        end
      end
      ias_pkg::ST_WRITE: begin
        state_d = ias_pkg::ST_FINISH;
      end
      ias_pkg::ST_FINISH: begin
        if (res_ready_i) begin
          state_d = ias_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ias_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d     = count_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    rd_addr_d   = rd_addr_q;
    wr_addr_d   = wr_addr_q;
    up_d        = up_q;
    rd_more_d   = rd_more_q;
    pend_d      = pend_q;
    capture_d   = capture_q;
    do_write_d  = do_write_q;
    val_d       = val_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_addr_q;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ias_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d      = value_i;
          rd_more_d  = op_ok && op_scan;
          pend_d     = 1'b0;
          capture_d  = 1'b0;
          do_write_d = op_write;
          up_d       = 1'b1;
          res_d.ok   = op_ok;
          res_d.data = '0;
          if (op_ok) begin
            unique case (ias_pkg::func_e'(func_i))
              ias_pkg::FUNC_PUSH: begin
                wr_addr_d = count_q[AddrW-1:0];
                count_d   = count_q + CntW'(1);
              end
              ias_pkg::FUNC_POP: begin
                ptr_d     = cnt_m1[AddrW-1:0];
                last_d    = cnt_m1[AddrW-1:0];
                capture_d = 1'b1;
                count_d   = cnt_m1;
              end
              ias_pkg::FUNC_GET: begin
                ptr_d     = idx_addr;
                last_d    = idx_addr;
                capture_d = 1'b1;
              end
              ias_pkg::FUNC_INSERT: begin
                wr_addr_d = idx_addr;
                ptr_d     = cnt_m1[AddrW-1:0];
                last_d    = idx_addr;
                up_d      = 1'b0;
                count_d   = count_q + CntW'(1);
              end
              ias_pkg::FUNC_REMOVE: begin
                ptr_d     = idx_addr;
                last_d    = cnt_m1[AddrW-1:0];
                capture_d = 1'b1;
                count_d   = cnt_m1;
              end
              default: begin
                count_d = count_q;
              end
            endcase
          end
          res_d.occ = ias_pkg::OccW'(count_d);
        end
      end
      ias_pkg::ST_SCAN: begin
        mem_re_o  = rd_more_q;
        pend_d    = rd_more_q;
        rd_addr_d = ptr_q;
        if (rd_more_q) begin
          ptr_d = up_q ? ptr_q + AddrW'(1) : ptr_q - AddrW'(1);
          if (ptr_q == last_q) begin
            rd_more_d = 1'b0;
          end
        end
        if (pend_q) begin
          if (capture_q) begin
            res_d.data = mem_rdata_i;
            capture_d  = 1'b0;
          end else begin
            // shift: one entry moves per cycle
            mem_we_o    = 1'b1;
            mem_waddr_o = up_q ? rd_addr_q - AddrW'(1) : rd_addr_q + AddrW'(1);
            mem_wdata_o = mem_rdata_i;
          end
        end
      end
      ias_pkg::ST_WRITE: begin
        mem_we_o = 1'b1;
      end
      ias_pkg::ST_FINISH: begin
        res_valid_o = 1'b1;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ias_pkg::ST_IDLE;
      count_q    <= '0;
      rd_more_q  <= 1'b0;
      pend_q     <= 1'b0;
      capture_q  <= 1'b0;
      do_write_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_more_q  <= rd_more_d;
      pend_q     <= pend_d;
      capture_q  <= capture_d;
      do_write_q <= do_write_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    last_q    <= last_d;
    rd_addr_q <= rd_addr_d;
    wr_addr_q <= wr_addr_d;
    up_q      <= up_d;
    val_q     <= val_d;
    res_q     <= res_d;
  end

  assign res_o = res_q;

endmodule

/* design/indexed_array_store_unit.sv */
// channel | signals                            | direction
// --------+------------------------------------+----------
// in      | in_valid_i/in_ready_o, func_i,     | input
//         | index_i, value_i                   |
// out     | out_valid_o/out_ready_i, ok_o,     | output
//         | read_value_o, occupancy_o          |
//
// Insert and remove shift the stored entries through the entry RAM, one entry
// per cycle; push, append insert, get, pop and rejected ops do not shift.
// Reset clears the count and control only; entries need no clearing pass.
// A result waits in the output register while the next transaction runs;
// the sequencer holds its result only if that register is still full.
module indexed_array_store_unit #(
  parameter int unsigned Depth = ias_pkg::DefaultDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ias_pkg::FuncW-1:0]        func_i,
  input  logic [ias_pkg::IndexW-1:0]       index_i,
  input  logic signed [ias_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             ok_o,
  output logic signed [ias_pkg::DataW-1:0] read_value_o,
  output logic [ias_pkg::OccW-1:0]         occupancy_o
);

  localparam int unsigned AddrW = $clog2(Depth);

  logic                             mem_we, mem_re;
  logic [AddrW-1:0]                 mem_waddr, mem_raddr;
  logic signed [ias_pkg::DataW-1:0] mem_wdata, mem_rdata;
  logic                             res_valid, res_ready;
  ias_pkg::result_t                 res;

  logic             out_valid_q, out_valid_d;
  ias_pkg::result_t out_q, out_d;

  ias_seq #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ias_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_q.ok;
  assign read_value_o = out_q.data;
  assign occupancy_o  = out_q.occ;

endmodule

/* bench/indexed_array_store_unit_test.sv */
module indexed_array_store_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  class ias_scoreboard;
    localparam int Cap = ias_pkg::DefaultDepth;

    logic signed [ias_pkg::DataW-1:0] words [Cap];
    logic [ias_pkg::OccW-1:0]         fill;
    ias_pkg::result_t                 expected [$];
    int                               errors;
    int                               seen;

    function new();
      fill   = '0;
      errors = 0;
      seen   = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Track the array contents and queue the response for one accepted transaction.
    function void note_request(logic [ias_pkg::FuncW-1:0] f,
                               logic [ias_pkg::IndexW-1:0] idx,
                               logic signed [ias_pkg::DataW-1:0] val);
      ias_pkg::result_t want;
      want.ok   = 1'b0;
      want.data = '0;
      case (f)
        ias_pkg::FUNC_PUSH: begin
          if (fill < Cap) begin
            words[fill] = val;
            fill++;
            want.ok = 1'b1;
          end
        end
        ias_pkg::FUNC_POP: begin
          if (fill > 0) begin
            fill--;
            want.data = words[fill];
            want.ok   = 1'b1;
          end
        end
        ias_pkg::FUNC_GET: begin
          if (idx < fill) begin
            want.data = words[idx];
            want.ok   = 1'b1;
          end
        end
        ias_pkg::FUNC_INSERT: begin
          if (idx <= fill && fill < Cap) begin
            for (int n = fill; n > idx; n--) words[n] = words[n-1];
            words[idx] = val;
            fill++;
            want.ok = 1'b1;
          end
        end
        ias_pkg::FUNC_REMOVE: begin
          if (idx < fill) begin
            want.data = words[idx];
            for (int n = idx + 1; n < fill; n++) words[n-1] = words[n];
            fill--;
            want.ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
      want.occ = fill;
      expected.push_back(want);
    endfunction

    task check_result(logic ok, logic signed [ias_pkg::DataW-1:0] rd,
                      logic [ias_pkg::OccW-1:0] occ);
      ias_pkg::result_t want;
      seen++;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("response %0d unexpected: ok=%0b data=%0d occ=%0d",
                                  seen, ok, rd, occ));
        return;
      end
      want = expected.pop_front();
      if (ok !== want.ok)
        report_mismatch($sformatf("response %0d ok: got %0b want %0b", seen, ok, want.ok));
      if (rd !== want.data)
        report_mismatch($sformatf("response %0d data: got %0d want %0d", seen, rd,
                                  want.data));
      if (occ !== want.occ)
        report_mismatch($sformatf("response %0d occupancy: got %0d want %0d", seen, occ,
                                  want.occ));
    endtask
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [ias_pkg::FuncW-1:0]        func_i;
  logic [ias_pkg::IndexW-1:0]       index_i;
  logic signed [ias_pkg::DataW-1:0] value_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic                             ok_o;
  logic signed [ias_pkg::DataW-1:0] read_value_o;
  logic [ias_pkg::OccW-1:0]         occupancy_o;

  ias_scoreboard sb = new();

  int unsigned send_idle;
  int unsigned recv_idle;
  bit          hold_req;
  int          hold_left;

  indexed_array_store_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .read_value_o(read_value_o),
    .occupancy_o (occupancy_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic send_request(input logic [ias_pkg::FuncW-1:0] f,
                              input logic [ias_pkg::IndexW-1:0] idx,
                              input logic signed [ias_pkg::DataW-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= f;
    index_i    <= idx;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(f, idx, val);
  endtask

  // Valid index most of the time, anything in the 9-bit range otherwise.
  function automatic logic [ias_pkg::IndexW-1:0] pick_index(int unsigned span);
    if (span > 0 && $urandom_range(99) < 85)
      return ias_pkg::IndexW'($urandom_range(span - 1));
    return ias_pkg::IndexW'($urandom_range(511));
  endfunction

  task automatic send_random(input bit growing, output logic [ias_pkg::FuncW-1:0] f);
    int unsigned                      r;
    logic [ias_pkg::IndexW-1:0]       idx;
    logic signed [ias_pkg::DataW-1:0] val;
    r   = $urandom_range(99);
    idx = ias_pkg::IndexW'($urandom_range(511));
    val = $urandom;
    if (growing) begin
      if (r < 55)      f = ias_pkg::FUNC_PUSH;
      else if (r < 85) f = ias_pkg::FUNC_INSERT;
      else if (r < 90) f = ias_pkg::FUNC_GET;
      else if (r < 94) f = ias_pkg::FUNC_POP;
      else if (r < 97) f = ias_pkg::FUNC_REMOVE;
      else             f = ias_pkg::FuncW'($urandom_range(7, 5));
    end else begin
      if (r < 10)      f = ias_pkg::FUNC_PUSH;
      else if (r < 20) f = ias_pkg::FUNC_INSERT;
      else if (r < 30) f = ias_pkg::FUNC_GET;
      else if (r < 60) f = ias_pkg::FUNC_POP;
      else if (r < 90) f = ias_pkg::FUNC_REMOVE;
      else             f = ias_pkg::FuncW'($urandom_range(7, 5));
    end
    case (f)
      ias_pkg::FUNC_INSERT:                    idx = pick_index(sb.fill + 1);
      ias_pkg::FUNC_GET, ias_pkg::FUNC_REMOVE: idx = pick_index(sb.fill);
      default: begin
      end
    endcase
    send_request(f, idx, val);
  endtask

  // Response side: random back-pressure plus one long hold on request.
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = 400;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(ok_o, read_value_o, occupancy_o);
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [ias_pkg::FuncW-1:0] f;
    bit                        growing;
    int                        counted;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = '0;
    index_i    = '0;
    value_i    = '0;
    hold_req   = 1'b0;
    send_idle  = 36;
    recv_idle  = 83;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty-store rejections
    send_request(ias_pkg::FUNC_POP, 9'd0, 32'sd5);
    send_request(ias_pkg::FUNC_GET, 9'd0, 32'sd0);
    send_request(ias_pkg::FUNC_REMOVE, 9'd0, 32'sd0);
    send_request(ias_pkg::FUNC_INSERT, 9'd1, 32'sd7);
    // fill with extreme words, insert at head, middle and tail
    send_request(ias_pkg::FUNC_INSERT, 9'd0, 32'sh8000_0000);
    send_request(ias_pkg::FUNC_PUSH, 9'd511, 32'sh7fff_ffff);
    send_request(ias_pkg::FUNC_PUSH, 9'd256, -32'sd1);
    send_request(ias_pkg::FUNC_PUSH, 9'd0, 32'sd0);
    send_request(ias_pkg::FUNC_INSERT, 9'd1, 32'sd12345);
    send_request(ias_pkg::FUNC_INSERT, sb.fill, 32'sh5555_aaaa);
    send_request(ias_pkg::FUNC_GET, 9'd0, 32'sd0);
    send_request(ias_pkg::FUNC_GET, ias_pkg::IndexW'(sb.fill - 1), 32'sd0);
    send_request(ias_pkg::FUNC_GET, sb.fill, 32'sd0);
    send_request(ias_pkg::FUNC_GET, 9'd511, -32'sd1);
    send_request(ias_pkg::FUNC_INSERT, ias_pkg::IndexW'(sb.fill + 1), 32'sd9);
    send_request(ias_pkg::FUNC_REMOVE, 9'd0, 32'sd0);
    send_request(ias_pkg::FUNC_REMOVE, ias_pkg::IndexW'(sb.fill - 1), 32'sd0);
    send_request(ias_pkg::FUNC_REMOVE, 9'd1, 32'sd0);
    send_request(ias_pkg::FUNC_REMOVE, sb.fill, 32'sd0);
    send_request(ias_pkg::FuncW'(5), 9'd0, 32'sd1);
    send_request(ias_pkg::FuncW'(6), 9'd511, -32'sd1);
    send_request(ias_pkg::FuncW'(7), 9'd256, 32'sh8000_0000);
    send_request(ias_pkg::FUNC_POP, 9'd3, 32'sd0);

    growing = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 36; recv_idle = 83; end
        1: begin send_idle = 83; recv_idle = 36; end
        default: begin send_idle = 0; recv_idle = 0; hold_req = 1'b1; end
      endcase
      counted = 0;
      while (counted < 200) begin
        if (growing && sb.fill == ias_pkg::DefaultDepth && $urandom_range(3) == 0)
          growing = 1'b0;
        else if (!growing && sb.fill < 8 && $urandom_range(3) == 0)
          growing = 1'b1;
        send_random(growing, f);
        if (f <= ias_pkg::FUNC_REMOVE) counted++;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
